// ===== sv/sfd_pkg.sv =====
// Package for the sensor frame deframer: frame geometry, marker bytes,
// field codes, decode constants and the field layout table. No dependencies.
`default_nettype none

package sfd_pkg;

  localparam int FRAME_BYTES = 60;
  localparam int AW = $clog2(FRAME_BYTES);       // window RAM address width
  localparam int FW = $clog2(FRAME_BYTES + 1);   // fill count width

  localparam logic [7:0] SYNC0_BYTE = 8'hAB;
  localparam logic [7:0] SYNC1_BYTE = 8'h14;
  localparam logic [7:0] TAIL_BYTE  = 8'h5A;

  // field codes
  localparam logic [3:0] FID_SPEED0   = 4'd0;
  localparam logic [3:0] FID_SPEED3   = 4'd3;
  localparam logic [3:0] FID_HEADING  = 4'd4;
  localparam logic [3:0] FID_PITCH    = 4'd5;
  localparam logic [3:0] FID_ROLL     = 4'd6;
  localparam logic [3:0] FID_ALT0     = 4'd7;
  localparam logic [3:0] FID_ALT5     = 4'd12;
  localparam logic [3:0] FID_PRESSURE = 4'd13;
  localparam logic [3:0] FID_TEMP     = 4'd14;
  localparam logic [3:0] FID_LEAK     = 4'd15;

  // pressure: (v - 16384) * 100 / 32768; temperature: v - 384 - 16000
  localparam logic signed [16:0] PRESS_OFFSET = 17'sd16384;
  localparam logic signed [7:0]  PRESS_SCALE  = 8'sd100;
  localparam int                 PRESS_SHIFT  = 15;
  localparam logic signed [16:0] TEMP_OFFSET  = 17'sd16384;

  typedef enum logic [2:0] {
    SFD_IDLE,
    SFD_EVICT,
    SFD_HDR0,
    SFD_HDR1,
    SFD_ERR,
    SFD_RD,
    SFD_ACC,
    SFD_OUT
  } sfd_state_t;

  typedef struct packed {
    logic [5:0] pos;   // first byte of the field in the window
    logic [2:0] nb;    // byte count
    logic       le;    // little-endian
  } field_desc_t;

  function automatic field_desc_t field_desc(input logic [3:0] fid);
    field_desc_t d;
    d = '{pos: 6'd0, nb: 3'd1, le: 1'b0};
    case (fid)
      4'd0:  d = '{pos: 6'd3,  nb: 3'd4, le: 1'b1};
      4'd1:  d = '{pos: 6'd7,  nb: 3'd4, le: 1'b1};
      4'd2:  d = '{pos: 6'd11, nb: 3'd4, le: 1'b1};
      4'd3:  d = '{pos: 6'd15, nb: 3'd4, le: 1'b1};
      4'd4:  d = '{pos: 6'd37, nb: 3'd4, le: 1'b0};
      4'd5:  d = '{pos: 6'd42, nb: 3'd4, le: 1'b0};
      4'd6:  d = '{pos: 6'd47, nb: 3'd4, le: 1'b0};
      4'd7:  d = '{pos: 6'd24, nb: 3'd2, le: 1'b0};
      4'd8:  d = '{pos: 6'd26, nb: 3'd2, le: 1'b0};
      4'd9:  d = '{pos: 6'd28, nb: 3'd2, le: 1'b0};
      4'd10: d = '{pos: 6'd30, nb: 3'd2, le: 1'b0};
      4'd11: d = '{pos: 6'd32, nb: 3'd2, le: 1'b0};
      4'd12: d = '{pos: 6'd34, nb: 3'd2, le: 1'b0};
      4'd13: d = '{pos: 6'd20, nb: 3'd2, le: 1'b0};
      4'd14: d = '{pos: 6'd22, nb: 3'd2, le: 1'b0};
      4'd15: d = '{pos: 6'd51, nb: 3'd1, le: 1'b0};
      default: d = '{pos: 6'd0, nb: 3'd1, le: 1'b0};
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== sv/sfd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/sensor_frame_deframer.sv =====
// Sensor frame deframer top level: circular byte window in sfd_ram, header and
// checksum check, field-by-field decode sequencer. Depends on sfd_pkg, sfd_ram.
//
// Each received byte is handled in two steps: a read of the byte it evicts,
// then the write; a byte that completes a window ending 5A 5A adds the two
// header reads. A good frame then decodes 16 fields, reading the window a byte
// at a time (a read, then an accumulate step) through the single RAM read port
// (45 bytes), each field closed by an output step that waits for the sink.
// The frame checksum is a running XOR kept alongside the window, so it costs
// no extra pass. in_ready is high only while the sequencer is idle; the last
// result may still sit in the output register while the next byte is taken.
// No clearing pass after reset.
`default_nettype none

module sensor_frame_deframer
  import sfd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [3:0]         out_field_id,
  output logic signed [32:0]      out_field_value,
  output logic                    out_checksum_bad,
  output logic                    out_last_of_frame
);

  sfd_state_t state_r, state_nxt;

  logic [AW-1:0] wp_r, wp_inc;
  logic [FW-1:0] fill_r, fill_inc;
  logic          primed_r;
  logic [7:0]    byte_r;
  logic [7:0]    x_r;
  logic [7:0]    tail0_r, tail1_r;
  logic [3:0]    fid_r;
  logic [1:0]    k_r;
  logic [31:0]   acc_r;

  logic          out_valid_r;
  logic [3:0]    out_id_r;
  logic signed [32:0] out_value_r;
  logic          out_bad_r, out_last_r;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          in_accept, out_free;
  logic          tail_hit, csum_ok, last_byte;
  field_desc_t   desc;
  logic [1:0]    byte_off;
  logic [AW-1:0] pos_sel;
  logic [AW:0]   pos_sum;
  logic [AW-1:0] pos_addr;
  logic          load_err, load_field;
  logic signed [32:0] field_value;

  logic signed [16:0] word_s;
  logic signed [16:0] press_d;
  logic signed [23:0] press_p;
  logic signed [23:0] press_q;
  logic [7:0]         expo;

  sfd_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (byte_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign wp_inc   = (wp_r == AW'(FRAME_BYTES - 1)) ? '0 : wp_r + 1'b1;
  assign fill_inc = (fill_r == FW'(FRAME_BYTES)) ? fill_r : fill_r + 1'b1;

  // after this write the window ends tail1_r, byte_r
  assign tail_hit = (fill_inc == FW'(FRAME_BYTES)) && (tail1_r == TAIL_BYTE)
                    && (byte_r == TAIL_BYTE);
  // XOR of bytes 0..N-4 equals byte N-3 iff whole-window XOR ^ last two == 0
  assign csum_ok  = ((x_r ^ tail0_r ^ tail1_r) == 8'h00);

  assign desc      = field_desc(fid_r);
  assign last_byte = ({1'b0, k_r} == desc.nb - 3'd1);
  assign byte_off  = desc.le ? 2'(desc.nb - 3'd1 - {1'b0, k_r}) : k_r;

  // window position -> RAM address, oldest byte at wp_r
  assign pos_sum  = {1'b0, wp_r} + {1'b0, pos_sel};
  assign pos_addr = (pos_sum >= (AW+1)'(FRAME_BYTES)) ?
                    AW'(pos_sum - (AW+1)'(FRAME_BYTES)) : AW'(pos_sum);

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SFD_IDLE:  if (in_valid) state_nxt = SFD_EVICT;
      SFD_EVICT: state_nxt = tail_hit ? SFD_HDR0 : SFD_IDLE;
      SFD_HDR0:  state_nxt = (ram_rdata == SYNC0_BYTE) ? SFD_HDR1 : SFD_IDLE;
      SFD_HDR1: begin
        if (ram_rdata != SYNC1_BYTE) state_nxt = SFD_IDLE;
        else if (csum_ok)            state_nxt = SFD_RD;
        else                         state_nxt = SFD_ERR;
      end
      SFD_ERR:   if (out_free) state_nxt = SFD_IDLE;
      SFD_RD:    state_nxt = SFD_ACC;
      SFD_ACC:   state_nxt = last_byte ? SFD_OUT : SFD_RD;
      SFD_OUT: begin
        if (out_free) begin
          state_nxt = (fid_r == FID_LEAK) ? SFD_IDLE : SFD_RD;
        end
      end
      default:   state_nxt = SFD_IDLE;
    endcase
  end

  // ---------------- outputs of the sequencer ----------------
  always_comb begin
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = wp_r;
    pos_sel    = '0;
    load_err   = 1'b0;
    load_field = 1'b0;
    case (state_r)
      SFD_IDLE: begin
        in_ready  = 1'b1;
        ram_re    = in_valid;      // fetch the byte about to be evicted
        ram_raddr = wp_r;
      end
      SFD_EVICT: begin
        ram_we    = 1'b1;
        ram_re    = tail_hit;      // window byte 0 is the new oldest
        ram_raddr = wp_inc;
      end
      SFD_HDR0: begin
        ram_re    = 1'b1;
        pos_sel   = AW'(1);
        ram_raddr = pos_addr;
      end
      SFD_RD: begin
        ram_re    = 1'b1;
        pos_sel   = AW'(desc.pos) + AW'(byte_off);
        ram_raddr = pos_addr;
      end
      SFD_ERR:  load_err   = out_free;
      SFD_OUT:  load_field = out_free;
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // ---------------- field decode ----------------
  assign word_s  = $signed({1'b0, acc_r[15:0]});
  assign press_d = word_s - PRESS_OFFSET;
  assign press_p = 24'(press_d) * 24'(PRESS_SCALE);
  // divide by 2^15 truncating toward zero
  assign press_q = press_p[23] ? ((press_p + 24'sd32767) >>> PRESS_SHIFT)
                               : (press_p >>> PRESS_SHIFT);
  assign expo    = acc_r[30:23];

  always_comb begin
    field_value = '0;
    case (fid_r) inside
      [FID_SPEED0:FID_SPEED3]: field_value = {acc_r[31], acc_r};
      [FID_HEADING:FID_ROLL]: begin
        if (expo == 8'h00 || expo == 8'hFF) field_value = '0;
        else                                field_value = {1'b0, acc_r};
      end
      [FID_ALT0:FID_ALT5]:     field_value = {17'd0, acc_r[15:0]};
      FID_PRESSURE:            field_value = 33'(press_q);
      FID_TEMP:                field_value = 33'(word_s - TEMP_OFFSET);
      FID_LEAK:                field_value = {25'd0, acc_r[7:0]};
      default:                 field_value = '0;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= SFD_IDLE;
      wp_r     <= '0;
      fill_r   <= '0;
      primed_r <= 1'b0;
      x_r      <= 8'h00;
      tail0_r  <= 8'h00;
      tail1_r  <= 8'h00;
      fid_r    <= '0;
      k_r      <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        SFD_EVICT: begin
          wp_r    <= wp_inc;
          fill_r  <= fill_inc;
          // unwritten entries count as zero until the window first fills
          x_r     <= x_r ^ byte_r ^ (primed_r ? ram_rdata : 8'h00);
          tail0_r <= tail1_r;
          tail1_r <= byte_r;
          if (fill_inc == FW'(FRAME_BYTES)) begin
            primed_r <= 1'b1;
          end
        end
        SFD_HDR1: begin
          if (ram_rdata == SYNC1_BYTE) begin
            fill_r <= '0;
            fid_r  <= '0;
            k_r    <= '0;
          end
        end
        SFD_ACC: begin
          if (!last_byte) begin
            k_r <= k_r + 1'b1;
          end
        end
        SFD_OUT: begin
          if (out_free) begin
            fid_r <= fid_r + 1'b1;
            k_r   <= '0;
          end
        end
        default: begin
          k_r <= k_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      byte_r <= in_rx_byte;
    end
    if (state_r == SFD_ACC) begin
      acc_r <= {acc_r[23:0], ram_rdata};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_err || load_field) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_err) begin
      out_id_r    <= FID_SPEED0;
      out_value_r <= '0;
      out_bad_r   <= 1'b1;
      out_last_r  <= 1'b1;
    end else if (load_field) begin
      out_id_r    <= fid_r;
      out_value_r <= field_value;
      out_bad_r   <= 1'b0;
      out_last_r  <= (fid_r == FID_LEAK);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_field_id      = out_id_r;
  assign out_field_value   = out_value_r;
  assign out_checksum_bad  = out_bad_r;
  assign out_last_of_frame = out_last_r;

  // ---------------- assertions ----------------
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(FRAME_BYTES))
    else $error("fill count above frame length");

  a_accept_writes: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> ram_we)
    else $error("accepted byte not written to window");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_checksum_bad) |-> (out_last_of_frame && out_field_id == FID_SPEED0))
    else $error("malformed checksum error beat");

  a_last_is_leak: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_frame && !out_checksum_bad) |-> (out_field_id == FID_LEAK))
    else $error("frame closed on wrong field");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (load_err || load_field) |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

endmodule

`default_nettype wire

// ===== bench/tb_sensor_frame_deframer.sv =====
// Self-checking bench for sensor_frame_deframer: streams link bytes, predicts the
// decoded fields of each framed window and checks every output beat in order.
// Depends on sfd_pkg and the sensor_frame_deframer RTL.
`timescale 1ns / 1ps

module tb_sensor_frame_deframer
  import sfd_pkg::*;
();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_TICKS = 150;    // margin for a decoded frame to finish
  localparam int RANDOM_BYTES = 30;

  typedef struct {
    logic [3:0]  fid;
    logic [32:0] value;
    logic        bad;
    logic        last;
  } decoded_field_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_rx_byte;
  logic out_valid;
  logic out_ready;
  logic [3:0] out_field_id;
  logic signed [32:0] out_field_value;
  logic out_checksum_bad;
  logic out_last_of_frame;

  sensor_frame_deframer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_field_id      (out_field_id),
    .out_field_value   (out_field_value),
    .out_checksum_bad  (out_checksum_bad),
    .out_last_of_frame (out_last_of_frame)
  );

  // predictor state
  logic [7:0] link_window [FRAME_BYTES];
  int unsigned link_fill = 0;
  decoded_field_t pending_fields [$];

  logic [7:0] frame_buf [FRAME_BYTES];
  int  sink_hold_cycles = 0;
  bit  steady_flow = 1'b0;
  int  bytes_sent = 0;
  int  frames_good = 0;
  int  frames_bad = 0;
  int  fields_checked = 0;
  int  mismatch_count = 0;
  int  cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic push_field(input logic [3:0] fid, input logic [32:0] value,
                            input logic bad, input logic last);
    decoded_field_t f;
    f = '{fid, value, bad, last};
    pending_fields.push_back(f);
  endtask

  // Slide one byte into the window and queue whatever the block must emit for it.
  task automatic decode_rx_byte(input logic [7:0] b);
    logic [7:0]  x;
    logic [31:0] w;
    int          v;
    int          p;
    for (int i = 0; i < FRAME_BYTES - 1; i++) link_window[i] = link_window[i + 1];
    link_window[FRAME_BYTES - 1] = b;
    if (link_fill < FRAME_BYTES) link_fill++;
    if (link_fill < FRAME_BYTES) return;
    if (link_window[0] != SYNC0_BYTE || link_window[1] != SYNC1_BYTE ||
        link_window[FRAME_BYTES - 2] != TAIL_BYTE ||
        link_window[FRAME_BYTES - 1] != TAIL_BYTE) return;
    link_fill = 0;
    x = 8'h00;
    for (int i = 0; i < FRAME_BYTES - 3; i++) x ^= link_window[i];
    if (x != link_window[FRAME_BYTES - 3]) begin
      frames_bad++;
      push_field(FID_SPEED0, 33'd0, 1'b1, 1'b1);
      return;
    end
    frames_good++;
    for (int k = 0; k < 4; k++) begin
      p = 3 + 4 * k;
      w = {link_window[p + 3], link_window[p + 2], link_window[p + 1], link_window[p]};
      push_field(FID_SPEED0 + 4'(k), {w[31], w}, 1'b0, 1'b0);
    end
    for (int k = 0; k < 3; k++) begin
      p = 37 + 5 * k;
      w = {link_window[p], link_window[p + 1], link_window[p + 2], link_window[p + 3]};
      // zero and all-ones exponents read as zero
      if (w[30:23] == 8'h00 || w[30:23] == 8'hFF) w = 32'd0;
      push_field(FID_HEADING + 4'(k), {1'b0, w}, 1'b0, 1'b0);
    end
    for (int k = 0; k < 6; k++) begin
      p = 24 + 2 * k;
      push_field(FID_ALT0 + 4'(k), {17'd0, link_window[p], link_window[p + 1]}, 1'b0, 1'b0);
    end
    // int division truncates toward zero
    v = {link_window[20], link_window[21]};
    v = (v - 16384) * 100 / 32768;
    push_field(FID_PRESSURE, {v[31], v}, 1'b0, 1'b0);
    v = {link_window[22], link_window[23]};
    v = v - 384 - 16000;
    push_field(FID_TEMP, {v[31], v}, 1'b0, 1'b0);
    push_field(FID_LEAK, {25'd0, link_window[51]}, 1'b0, 1'b1);
  endtask

  // Entered and left in the time step of a rising edge.
  task automatic send_byte(input logic [7:0] b);
    while (!steady_flow && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_byte(8'($urandom));
  endtask

  task automatic send_frame();
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(frame_buf[i]);
  endtask

  // Random payload with markers in place; spice pushes toward decode corners.
  task automatic build_frame(input bit spice);
    int p;
    for (int i = 0; i < FRAME_BYTES; i++) frame_buf[i] = 8'($urandom);
    frame_buf[0] = SYNC0_BYTE;
    frame_buf[1] = SYNC1_BYTE;
    frame_buf[FRAME_BYTES - 2] = TAIL_BYTE;
    frame_buf[FRAME_BYTES - 1] = TAIL_BYTE;
    if (spice) begin
      p = 37 + 5 * $urandom_range(2);
      case ($urandom_range(3))
        0: begin
          frame_buf[p]     &= 8'h80;
          frame_buf[p + 1] &= 8'h7F;
        end
        1: begin
          frame_buf[p]     |= 8'h7F;
          frame_buf[p + 1] |= 8'h80;
        end
        2: {frame_buf[20], frame_buf[21]} = 16'(16284 + $urandom_range(200));
        default: ;
      endcase
    end
  endtask

  task automatic seal_frame(input bit corrupt);
    logic [7:0] x;
    x = 8'h00;
    for (int i = 0; i < FRAME_BYTES - 3; i++) x ^= frame_buf[i];
    if (corrupt) x ^= 8'($urandom_range(255, 1));
    frame_buf[FRAME_BYTES - 3] = x;
  endtask

  task automatic set_frame_fields(input logic [3:0][31:0] spd, input logic [2:0][31:0] ang,
                                  input logic [5:0][15:0] alt, input logic [15:0] press,
                                  input logic [15:0] temp, input logic [7:0] leak);
    int p;
    for (int k = 0; k < 4; k++) begin
      p = 3 + 4 * k;
      {frame_buf[p + 3], frame_buf[p + 2], frame_buf[p + 1], frame_buf[p]} = spd[k];
    end
    for (int k = 0; k < 3; k++) begin
      p = 37 + 5 * k;
      {frame_buf[p], frame_buf[p + 1], frame_buf[p + 2], frame_buf[p + 3]} = ang[k];
    end
    for (int k = 0; k < 6; k++) {frame_buf[24 + 2 * k], frame_buf[25 + 2 * k]} = alt[k];
    {frame_buf[20], frame_buf[21]} = press;
    {frame_buf[22], frame_buf[23]} = temp;
    frame_buf[51] = leak;
  endtask

  task automatic wait_results_drained();
    while (pending_fields.size() != 0) @(posedge clk);
  endtask

  // markers before the window has filled must not frame
  task automatic test_partial_window();
    send_byte(SYNC0_BYTE);
    send_byte(SYNC1_BYTE);
    send_noise(4);
    send_byte(TAIL_BYTE);
    send_byte(TAIL_BYTE);
  endtask

  task automatic test_decode_extremes();
    build_frame(1'b0);
    set_frame_fields({32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h00000000},
                     {32'h807FFFFF, 32'h7F800001, 32'hC0490FDB},
                     {16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE},
                     16'h0000, 16'h0000, 8'hFF);
    seal_frame(1'b0);
    send_frame();
    build_frame(1'b0);
    set_frame_fields({32'h00000001, 32'h80000001, 32'h12345678, 32'hFEDCBA98},
                     {32'hFF800000, 32'h00000001, 32'h3F800000},
                     {16'h1234, 16'hABCD, 16'h5A5A, 16'hAB14, 16'h00FF, 16'hFF00},
                     16'h3FFF, 16'h4000, 8'h00);
    seal_frame(1'b0);
    send_frame();
  endtask

  task automatic test_checksum_error();
    build_frame(1'b0);
    seal_frame(1'b1);
    send_frame();
  endtask

  task automatic test_missing_markers();
    build_frame(1'b0);
    seal_frame(1'b0);
    frame_buf[1] = 8'h15;
    send_frame();
    build_frame(1'b0);
    seal_frame(1'b0);
    frame_buf[FRAME_BYTES - 1] = 8'h5B;
    send_frame();
  endtask

  // long sink stall fills the output path and blocks in_ready, then a full pause
  task automatic test_output_backpressure();
    sink_hold_cycles = 500;
    build_frame(1'b1);
    seal_frame(1'b0);
    send_frame();
    send_noise(8);
    wait_results_drained();
  endtask

  task automatic test_steady_stream();
    steady_flow = 1'b1;
    build_frame(1'b1);
    seal_frame(1'b0);
    send_frame();
    steady_flow = 1'b0;
  endtask

  task automatic test_random_traffic();
    int start;
    int pick;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_noise($urandom_range(20, 1));
      end else begin
        send_noise($urandom_range(3));
        build_frame(1'b1);
        seal_frame(pick >= 80 && pick < 92);
        if (pick >= 92) begin
          case ($urandom_range(3))
            0: frame_buf[0] ^= 8'($urandom_range(255, 1));
            1: frame_buf[1] ^= 8'($urandom_range(255, 1));
            2: frame_buf[FRAME_BYTES - 2] ^= 8'($urandom_range(255, 1));
            default: frame_buf[FRAME_BYTES - 1] ^= 8'($urandom_range(255, 1));
          endcase
        end
        send_frame();
      end
    end
  endtask

  // result sink
  initial begin
    int hold;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_cycles != 0) begin
        hold = sink_hold_cycles;
        sink_hold_cycles = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        out_ready <= steady_flow || ($urandom_range(99) >= 30);
      end
    end
  end

  // result checker
  initial begin
    decoded_field_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        fields_checked++;
        if (pending_fields.size() == 0) begin
          $error("unexpected beat: field_id %0d field_value %h", out_field_id,
                 out_field_value);
          mismatch_count++;
        end else begin
          want = pending_fields.pop_front();
          if (out_field_id !== want.fid) begin
            $error("field_id: expected %0d, got %0d", want.fid, out_field_id);
            mismatch_count++;
          end
          if (out_field_value !== want.value) begin
            $error("field_value (id %0d): expected %h, got %h", want.fid, want.value,
                   out_field_value);
            mismatch_count++;
          end
          if (out_checksum_bad !== want.bad) begin
            $error("checksum_bad: expected %0b, got %0b", want.bad, out_checksum_bad);
            mismatch_count++;
          end
          if (out_last_of_frame !== want.last) begin
            $error("last_of_frame (id %0d): expected %0b, got %0b", want.fid, want.last,
                   out_last_of_frame);
            mismatch_count++;
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sensor_frame_deframer: mismatch");
    $finish;
  end

  initial begin
    in_valid   <= 1'b0;
    in_rx_byte <= 8'h00;
    rst_n      <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_partial_window();
    test_decode_extremes();
    test_checksum_error();
    test_missing_markers();
    test_output_backpressure();
    test_steady_stream();
    test_random_traffic();

    in_valid <= 1'b0;
    wait_results_drained();
    repeat (SETTLE_TICKS) @(posedge clk);

    $display("Streamed %0d link bytes: %0d good frames, %0d checksum errors, %0d beats checked",
             bytes_sent, frames_good, frames_bad, fields_checked);
    $display("Included partial windows, broken markers, a long sink stall and a steady run");
    if (mismatch_count == 0 && pending_fields.size() == 0) begin
      $display("sensor_frame_deframer: match");
    end else begin
      $display("sensor_frame_deframer: mismatch");
    end
    $finish;
  end

endmodule

// ===== sensor_frame_deframer.f =====
sv/sfd_pkg.sv
sv/sfd_ram.sv
sv/sensor_frame_deframer.sv
bench/tb_sensor_frame_deframer.sv
